[rtl/msq_pkg.sv]
// Shared types, codes and helpers for the multimode sorted queue.
package msq_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int PAYLOAD_BYTES_DEF = 8;

    localparam logic [2:0] OP_ENQ    = 3'd0;
    localparam logic [2:0] OP_DEQ    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_FLUSH  = 3'd3;
    localparam logic [2:0] OP_EXPIRE = 3'd4;
    localparam logic [2:0] OP_STAT   = 3'd5;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_PRIO = 2'd1;
    localparam logic [1:0] MODE_DEAD = 2'd2;
    localparam logic [1:0] MODE_RR   = 2'd3;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_MAXB  = 2'd2;

    localparam logic [2:0] STAT_ENQ   = 3'd0;
    localparam logic [2:0] STAT_DEQ   = 3'd1;
    localparam logic [2:0] STAT_DROP  = 3'd2;
    localparam logic [2:0] STAT_TMO   = 3'd3;
    localparam logic [2:0] STAT_PEAK  = 3'd4;
    localparam logic [2:0] STAT_COUNT = 3'd5;

    localparam logic [2:0] ACT_HOLD   = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_SHIFT  = 3'd2;
    localparam logic [2:0] ACT_ROTATE = 3'd3;
    localparam logic [2:0] ACT_EXPIRE = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] payload;
        logic [3:0]  payload_size;
        logic [31:0] prio;
        logic [63:0] due_time;
        logic [63:0] now_time;
        logic [2:0]  stat_select;
    } msq_in_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] out_payload;
        logic [3:0]  out_size;
        logic [4:0]  removed_count;
        logic [31:0] stat_value;
        logic [4:0]  entry_count;
        logic        is_full;
        logic        is_empty;
    } msq_out_t;

    typedef struct packed {
        logic [63:0] payload;
        logic [3:0]  size;
        logic [31:0] prio;
        logic [63:0] deadline;
    } slot_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  mode;
        slot_t       new_ent;
        logic [63:0] now_time;
    } cell_ctl_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] size);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (b < int'(size))
                m[b*8 +: 8] = 8'hff;
        end
        return m;
    endfunction

endpackage

[rtl/msq_cell.sv]
// One queue slot: compares locally and takes its next entry from a neighbor, the head or the new entry.
module msq_cell
    import msq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
)
(
    input  logic          clk,
    input  cell_ctl_t     ctl,
    input  logic [CW-1:0] count,
    input  logic          seen_in,
    output logic          seen_out,
    input  slot_t         left,
    input  slot_t         right,
    input  slot_t         right2,
    input  slot_t         head,
    output slot_t         ent
);

    slot_t ent_reg;
    slot_t ent_next;
    logic  occupied;
    logic  lower;
    logic  hit;
    logic  first;

    always_comb
    begin
        occupied = 32'(count) > IDX;
        case (ctl.mode)
            MODE_PRIO: lower = ent_reg.prio < ctl.new_ent.prio;
            MODE_DEAD: lower = ent_reg.deadline > ctl.new_ent.deadline;
            default:   lower = 1'b0;
        endcase
        if (ctl.action == ACT_EXPIRE)
            hit = occupied && (ent_reg.deadline <= ctl.now_time);
        else
            hit = occupied && lower;
        first    = hit && !seen_in;
        seen_out = seen_in || hit;

        ent_next = ent_reg;
        case (ctl.action)
            ACT_INSERT:
            begin
                // entries behind the insertion point move back one slot
                if (seen_in)
                    ent_next = left;
                else if (first || (32'(count) == IDX))
                    ent_next = ctl.new_ent;
            end
            ACT_SHIFT:
                ent_next = right;
            ACT_ROTATE:
            begin
                if (IDX + 2 < 32'(count))
                    ent_next = right2;
                else if (IDX + 2 == 32'(count))
                    ent_next = head;
            end
            ACT_EXPIRE:
            begin
                // drop the first expired entry, close the gap
                if (seen_out)
                    ent_next = right;
            end
            default:
                ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

[rtl/multimode_sorted_queue.sv]
// Top level: command control, counters and the row of queue cells.
// Sequence: start is taken in idle and moves control to execute; result and done are
// registered from execute. Remove expired stays in execute while it drops entries,
// one removal per pass of the cell row. Start is taken only in idle, not while busy.
// Reset: asynchronous, clears count, counters and control; the queue reads as empty.
// The receiver cannot stall: each result is shown for one cycle with done high.
module multimode_sorted_queue
    import msq_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  msq_in_t    cmd,
    output logic       done,
    output msq_out_t   rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic          state_reg, state_next;
    msq_in_t       req_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] peak_reg, peak_next;
    logic [CW-1:0] removed_reg, removed_next;
    logic [31:0]   enq_reg, enq_next;
    logic [31:0]   deq_reg, deq_next;
    logic [31:0]   drop_reg, drop_next;
    logic [31:0]   tmo_reg, tmo_next;
    logic [1:0]    mode_reg;
    logic [4:0]    limit_reg;
    logic [3:0]    maxb_reg;
    logic          done_reg, done_next;
    msq_out_t      rsp_reg, rsp_next;

    cell_ctl_t     ctl;
    slot_t         ent [CAPACITY];
    logic          seen [CAPACITY+1];

    logic          ok;
    logic [63:0]   opay;
    logic [3:0]    osize;
    logic [CW-1:0] removed;
    logic [31:0]   stat;
    logic          finish;
    logic          full_now;

    assign seen[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        slot_t left_w, right_w, right2_w;
        assign left_w   = (i > 0) ? ent[(i > 0) ? i-1 : 0] : ctl.new_ent;
        assign right_w  = (i + 1 < CAPACITY) ? ent[(i + 1 < CAPACITY) ? i+1 : i] : ent[i];
        assign right2_w = (i + 2 < CAPACITY) ? ent[(i + 2 < CAPACITY) ? i+2 : i] : ent[i];
        msq_cell #(.IDX(i), .CW(CW)) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .count    (count_reg),
            .seen_in  (seen[i]),
            .seen_out (seen[i+1]),
            .left     (left_w),
            .right    (right_w),
            .right2   (right2_w),
            .head     (ent[0]),
            .ent      (ent[i])
        );
    end

    always_comb
    begin
        ctl.action           = ACT_HOLD;
        ctl.mode             = mode_reg;
        ctl.new_ent.payload  = req_reg.payload & byte_mask(req_reg.payload_size);
        ctl.new_ent.size     = req_reg.payload_size;
        ctl.new_ent.prio     = req_reg.prio;
        ctl.new_ent.deadline = req_reg.due_time;
        ctl.now_time         = req_reg.now_time;

        state_next   = state_reg;
        count_next   = count_reg;
        peak_next    = peak_reg;
        removed_next = removed_reg;
        enq_next     = enq_reg;
        deq_next     = deq_reg;
        drop_next    = drop_reg;
        tmo_next     = tmo_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;

        ok      = 1'b0;
        opay    = '0;
        osize   = '0;
        removed = '0;
        stat    = '0;
        finish  = 1'b1;
        full_now = (32'(count_reg) >= 32'(limit_reg)) || (32'(count_reg) >= CAPACITY);

        if (state_reg == ST_IDLE)
        begin
            finish = 1'b0;
            if (start)
            begin
                state_next   = ST_EXEC;
                removed_next = '0;
            end
        end
        else
        begin
            case (req_reg.op)
                OP_ENQ:
                begin
                    if ((req_reg.payload_size <= maxb_reg)
                        && (32'(req_reg.payload_size) <= PAYLOAD_BYTES))
                    begin
                        if (full_now)
                            tmo_next = tmo_reg + 32'd1;
                        else
                        begin
                            ctl.action = ACT_INSERT;
                            count_next = count_reg + CW'(1);
                            enq_next   = enq_reg + 32'd1;
                            if (count_next > peak_reg)
                                peak_next = count_next;
                            ok = 1'b1;
                        end
                    end
                end
                OP_DEQ:
                begin
                    if (count_reg == '0)
                        tmo_next = tmo_reg + 32'd1;
                    else
                    begin
                        if ((mode_reg == MODE_RR) && (32'(count_reg) >= 2))
                        begin
                            ctl.action = ACT_ROTATE;
                            opay       = ent[1].payload;
                            osize      = ent[1].size;
                        end
                        else
                        begin
                            ctl.action = ACT_SHIFT;
                            opay       = ent[0].payload;
                            osize      = ent[0].size;
                        end
                        count_next = count_reg - CW'(1);
                        deq_next   = deq_reg + 32'd1;
                        ok         = 1'b1;
                    end
                end
                OP_PEEK:
                begin
                    if (count_reg != '0)
                    begin
                        opay  = ent[0].payload;
                        osize = ent[0].size;
                        ok    = 1'b1;
                    end
                end
                OP_FLUSH:
                begin
                    removed    = count_reg;
                    drop_next  = drop_reg + 32'(count_reg);
                    count_next = '0;
                    ok         = 1'b1;
                end
                OP_EXPIRE:
                begin
                    ctl.action = ACT_EXPIRE;
                    if (seen[CAPACITY])
                    begin
                        // one entry dropped this pass; go around again
                        finish       = 1'b0;
                        count_next   = count_reg - CW'(1);
                        removed_next = removed_reg + CW'(1);
                        drop_next    = drop_reg + 32'd1;
                    end
                    else
                    begin
                        removed = removed_reg;
                        ok      = 1'b1;
                    end
                end
                OP_STAT:
                begin
                    ok = 1'b1;
                    case (req_reg.stat_select)
                        STAT_ENQ:   stat = enq_reg;
                        STAT_DEQ:   stat = deq_reg;
                        STAT_DROP:  stat = drop_reg;
                        STAT_TMO:   stat = tmo_reg;
                        STAT_PEAK:  stat = 32'(peak_reg);
                        STAT_COUNT: stat = 32'(count_reg);
                        default:    ok = 1'b0;
                    endcase
                end
                default:
                    ok = 1'b0;
            endcase
        end

        if (finish)
        begin
            state_next             = ST_IDLE;
            done_next              = 1'b1;
            rsp_next.ok            = ok;
            rsp_next.out_payload   = opay;
            rsp_next.out_size      = osize;
            rsp_next.removed_count = 5'(removed);
            rsp_next.stat_value    = stat;
            rsp_next.entry_count   = 5'(count_next);
            rsp_next.is_full       = (32'(count_next) >= 32'(limit_reg))
                                     || (32'(count_next) >= CAPACITY);
            rsp_next.is_empty      = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            peak_reg    <= '0;
            removed_reg <= '0;
            enq_reg     <= '0;
            deq_reg     <= '0;
            drop_reg    <= '0;
            tmo_reg     <= '0;
            done_reg    <= 1'b0;
            mode_reg    <= MODE_FIFO;
            limit_reg   <= 5'd16;
            maxb_reg    <= 4'd8;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            peak_reg    <= peak_next;
            removed_reg <= removed_next;
            enq_reg     <= enq_next;
            deq_reg     <= deq_next;
            drop_reg    <= drop_next;
            tmo_reg     <= tmo_next;
            done_reg    <= done_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_MODE:  mode_reg  <= cfg_data[1:0];
                    REG_LIMIT: limit_reg <= cfg_data[4:0];
                    REG_MAXB:  maxb_reg  <= cfg_data[3:0];
                    default:   mode_reg  <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if ((state_reg == ST_IDLE) && start)
            req_reg <= cmd;
    end

    assign busy      = (state_reg == ST_EXEC);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule
